>>> hdl/c8sfp_pkg.sv
// Shared types, codes and the CRC-8 step function for the CRC-8 frame parser.
// Used by the controller, the datapath and the top level. No dependencies.
package c8sfp_pkg;

    // Result status codes
    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_CRC_ERR = 2'd1;
    localparam logic [1:0] ST_LEN_ERR = 2'd2;

    // Configuration register indexes
    localparam logic CFG_FIRST_HDR  = 1'b0;
    localparam logic CFG_SECOND_HDR = 1'b1;

    // CRC-8 polynomial 0x31, MSB first
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_TOP  = 8'h80;

    // Controller to datapath commands
    typedef struct packed {
        logic       cap_id;      // capture id, start CRC
        logic       cap_len;     // capture length, update CRC, clear fill
        logic       wr_data;     // store payload byte, update CRC
        logic       emit;        // load a single result (error or empty frame)
        logic [1:0] emit_status;
        logic       burst_clr;   // rewind burst read index
        logic       burst_load;  // load one payload result from memory
    } c8sfp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic hdr1_eq;     // input byte equals first header
        logic hdr2_eq;     // input byte equals second header
        logic len_big;     // input byte exceeds payload store
        logic in_zero;     // input byte is zero
        logic len_zero;    // held length is zero
        logic crc_eq;      // input byte equals running CRC
        logic fill_done;   // this payload byte completes the payload
        logic out_free;    // output register can take a result
        logic burst_last;  // current burst entry is the final one
    } c8sfp_stat_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
        logic [7:0] v;
        v = acc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            if ((v & CRC_TOP) != 8'd0)
                v = (v << 1) ^ CRC_POLY;
            else
                v = v << 1;
        end
        return v;
    endfunction

endpackage

>>> hdl/c8sfp_byte_if.sv
// Valid/ready channel carrying one received byte per transaction.
// No dependencies.
interface c8sfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
    modport monitor (input valid, input in_byte, input ready);
endinterface

>>> hdl/c8sfp_result_if.sv
// Valid/ready channel carrying one parser result per transaction.
// No dependencies.
interface c8sfp_result_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [7:0] frame_id;
    logic [7:0] frame_length;
    logic [4:0] byte_index;
    logic [7:0] payload_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, output status, output frame_id, output frame_length,
                    output byte_index, output payload_byte, output byte_valid,
                    output last, input ready);
    modport sink (input valid, input status, input frame_id, input frame_length,
                  input byte_index, input payload_byte, input byte_valid,
                  input last, output ready);
    modport monitor (input valid, input status, input frame_id, input frame_length,
                     input byte_index, input payload_byte, input byte_valid,
                     input last, input ready);
endinterface

>>> hdl/crc8_serial_frame_parser_core.sv
// Top level of the CRC-8 serial frame parser: controller plus datapath.
// Depends on c8sfp_pkg, c8sfp_byte_if, c8sfp_result_if, c8sfp_ctrl, c8sfp_dp.
//
// Usage:
//   in_ch  : one received byte per transaction (in_byte).
//   out_ch : one result per transaction (status, frame_id, frame_length,
//            byte_index, payload_byte, byte_valid, last).
//   cfg_*  : write port for the two sync bytes (index 0 first, 1 second).
//            Write only while the parser is idle.
// Frames are header1, header2, id, length, payload, CRC-8 (poly 0x31, init 0,
// over id, length and payload).
// While parsing, a byte is taken whenever the output register is free. On a good
// CRC the payload is played back from the payload memory, each byte through a
// read state (registered read port) and then a load state (output register
// load); input is held off during that burst.
// An error or empty-frame result appears the cycle after the byte that caused
// it; the first payload result of a burst follows the CRC byte through the read
// and load states, and the load waits until the output register is free.
// Reset: parser returns to hunting for header1, sync bytes to 0xAA/0x55, no
// result pending. The payload memory is not cleared.
// Stall: a single output register holds a result until taken; while it is
// full and not being taken, in_ch.ready stays low and the burst waits.
module crc8_serial_frame_parser_core #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    cfg_we,
    input  logic    cfg_index,
    input  logic [7:0] cfg_data,
    c8sfp_byte_if.sink     in_ch,
    c8sfp_result_if.source out_ch
);
    import c8sfp_pkg::*;

    c8sfp_cmd_t  cmd;
    c8sfp_stat_t stat;

    // Frame phase sequencing and burst control
    c8sfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Header match, CRC, payload memory and result register
    c8sfp_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_byte          (in_ch.in_byte),
        .cmd              (cmd),
        .stat             (stat),
        .out_ready        (out_ch.ready),
        .out_valid        (out_ch.valid),
        .out_status       (out_ch.status),
        .out_frame_id     (out_ch.frame_id),
        .out_frame_length (out_ch.frame_length),
        .out_byte_index   (out_ch.byte_index),
        .out_payload_byte (out_ch.payload_byte),
        .out_byte_valid   (out_ch.byte_valid),
        .out_last         (out_ch.last)
    );

endmodule

>>> hdl/c8sfp_ctrl.sv
// Parse controller: frame phase state machine and payload burst sequencing.
// Depends on c8sfp_pkg.
module c8sfp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  c8sfp_pkg::c8sfp_stat_t stat,
    output c8sfp_pkg::c8sfp_cmd_t  cmd
);
    import c8sfp_pkg::*;

    localparam logic [2:0] PH_H1    = 3'd0;
    localparam logic [2:0] PH_H2    = 3'd1;
    localparam logic [2:0] PH_ID    = 3'd2;
    localparam logic [2:0] PH_LEN   = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CRC   = 3'd5;
    localparam logic [2:0] PH_RD    = 3'd6;
    localparam logic [2:0] PH_LD    = 3'd7;

    logic [2:0] state_reg, state_next;
    logic       resume_h2_reg, resume_h2_next;
    logic       accept;

    assign in_ready = (state_reg != PH_RD) && (state_reg != PH_LD) && stat.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next     = state_reg;
        resume_h2_next = resume_h2_reg;
        cmd            = '0;
        case (state_reg)
            PH_H1:
            begin
                if (accept && stat.hdr1_eq)
                    state_next = PH_H2;
            end
            PH_H2:
            begin
                if (accept)
                begin
                    if (stat.hdr2_eq)
                        state_next = PH_ID;
                    else if (stat.hdr1_eq)
                        state_next = PH_H2;
                    else
                        state_next = PH_H1;
                end
            end
            PH_ID:
            begin
                if (accept)
                begin
                    cmd.cap_id = 1'b1;
                    state_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (accept)
                begin
                    cmd.cap_len = 1'b1;
                    if (stat.len_big)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_LEN_ERR;
                        state_next      = PH_H1;
                    end
                    else if (stat.in_zero)
                        state_next = PH_CRC;
                    else
                        state_next = PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (accept)
                begin
                    cmd.wr_data = 1'b1;
                    if (stat.fill_done)
                        state_next = PH_CRC;
                end
            end
            PH_CRC:
            begin
                if (accept)
                begin
                    state_next = stat.hdr1_eq ? PH_H2 : PH_H1;
                    if (!stat.crc_eq)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_CRC_ERR;
                    end
                    else if (stat.len_zero)
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_GOOD;
                    end
                    else
                    begin
                        cmd.burst_clr  = 1'b1;
                        resume_h2_next = stat.hdr1_eq;
                        state_next     = PH_RD;
                    end
                end
            end
            PH_RD:
            begin
                state_next = PH_LD;
            end
            PH_LD:
            begin
                if (stat.out_free)
                begin
                    cmd.burst_load = 1'b1;
                    if (stat.burst_last)
                        state_next = resume_h2_reg ? PH_H2 : PH_H1;
                    else
                        state_next = PH_RD;
                end
            end
            default:
            begin
                state_next = PH_H1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= PH_H1;
            resume_h2_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resume_h2_reg <= resume_h2_next;
        end
    end

endmodule

>>> hdl/c8sfp_dp.sv
// Datapath: header registers, frame fields, CRC-8, payload memory and the
// output result register. Depends on c8sfp_pkg.
module c8sfp_dp #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [7:0]             cfg_data,
    input  logic [7:0]             in_byte,
    input  c8sfp_pkg::c8sfp_cmd_t  cmd,
    output c8sfp_pkg::c8sfp_stat_t stat,
    input  logic                   out_ready,
    output logic                   out_valid,
    output logic [1:0]             out_status,
    output logic [7:0]             out_frame_id,
    output logic [7:0]             out_frame_length,
    output logic [4:0]             out_byte_index,
    output logic [7:0]             out_payload_byte,
    output logic                   out_byte_valid,
    output logic                   out_last
);
    import c8sfp_pkg::*;

    localparam int         AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);
    localparam logic [6:0] MAX_POS = 7'(MAX_PAYLOAD);

    logic [7:0] hdr1_reg, hdr2_reg;
    logic [7:0] id_reg, id_next;
    logic [7:0] len_reg, len_next;
    logic [5:0] fill_reg, fill_next;
    logic [7:0] crc_reg, crc_next;
    logic [5:0] idx_reg, idx_next;
    logic [5:0] fill_inc;
    logic [7:0] crc_upd;

    logic [7:0] mem [MAX_PAYLOAD];
    logic [7:0] rd_data_reg;

    logic       out_valid_reg;
    logic [1:0] status_reg;
    logic [7:0] fid_reg, flen_reg, pbyte_reg;
    logic [4:0] bidx_reg;
    logic       bvalid_reg, last_reg;

    assign fill_inc = fill_reg + 6'd1;
    assign crc_upd  = crc8_step(crc_reg, in_byte);

    assign stat.hdr1_eq    = (in_byte == hdr1_reg);
    assign stat.hdr2_eq    = (in_byte == hdr2_reg);
    assign stat.len_big    = (in_byte > MAX_LEN);
    assign stat.in_zero    = (in_byte == 8'd0);
    assign stat.len_zero   = (len_reg == 8'd0);
    assign stat.crc_eq     = (in_byte == crc_reg);
    assign stat.fill_done  = ({2'b00, fill_inc} >= len_reg);
    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.burst_last = (({2'b00, idx_reg} + 8'd1) == len_reg);

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr1_reg <= 8'hAA;
            hdr2_reg <= 8'h55;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FIRST_HDR:  hdr1_reg <= cfg_data;
                CFG_SECOND_HDR: hdr2_reg <= cfg_data;
                default:        hdr1_reg <= hdr1_reg;
            endcase
        end
    end

    always_comb
    begin
        id_next   = id_reg;
        len_next  = len_reg;
        fill_next = fill_reg;
        crc_next  = crc_reg;
        idx_next  = idx_reg;
        if (cmd.cap_id)
        begin
            id_next  = in_byte;
            crc_next = crc8_step(8'd0, in_byte);
        end
        if (cmd.cap_len)
        begin
            len_next  = in_byte;
            crc_next  = crc_upd;
            fill_next = 6'd0;
        end
        if (cmd.wr_data)
        begin
            fill_next = fill_inc;
            crc_next  = crc_upd;
        end
        if (cmd.burst_clr)
            idx_next = 6'd0;
        else if (cmd.burst_load)
            idx_next = idx_reg + 6'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_reg   <= 8'd0;
            len_reg  <= 8'd0;
            fill_reg <= 6'd0;
            crc_reg  <= 8'd0;
            idx_reg  <= 6'd0;
        end
        else
        begin
            id_reg   <= id_next;
            len_reg  <= len_next;
            fill_reg <= fill_next;
            crc_reg  <= crc_next;
            idx_reg  <= idx_next;
        end
    end

    // Payload store: one write port during fill, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.wr_data && ({1'b0, fill_reg} < MAX_POS))
            mem[fill_reg[AW-1:0]] <= in_byte;
        rd_data_reg <= mem[idx_reg[AW-1:0]];
    end

    // Output result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit || cmd.burst_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            status_reg <= cmd.emit_status;
            fid_reg    <= id_reg;
            flen_reg   <= cmd.cap_len ? in_byte : len_reg;
            bidx_reg   <= 5'd0;
            pbyte_reg  <= 8'd0;
            bvalid_reg <= 1'b0;
            last_reg   <= 1'b1;
        end
        else if (cmd.burst_load)
        begin
            status_reg <= ST_GOOD;
            fid_reg    <= id_reg;
            flen_reg   <= len_reg;
            bidx_reg   <= idx_reg[4:0];
            pbyte_reg  <= rd_data_reg;
            bvalid_reg <= 1'b1;
            last_reg   <= stat.burst_last;
        end
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = status_reg;
    assign out_frame_id     = fid_reg;
    assign out_frame_length = flen_reg;
    assign out_byte_index   = bidx_reg;
    assign out_payload_byte = pbyte_reg;
    assign out_byte_valid   = bvalid_reg;
    assign out_last         = last_reg;

endmodule

>>> hdl/c8sfp_checker.sv
// Port-level checker for the CRC-8 frame parser, bound to the top level.
// Depends on c8sfp_pkg and the handshake and result ports of the top level.
module c8sfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_status,
    input logic [4:0] out_byte_index,
    input logic [7:0] out_payload_byte,
    input logic       out_byte_valid,
    input logic       out_last
);
    import c8sfp_pkg::*;

    // A stalled result holds its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result valid dropped while stalled");

    // Only the three defined status codes are produced
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_status == ST_GOOD || out_status == ST_CRC_ERR ||
                       out_status == ST_LEN_ERR))
        else $error("undefined status code");

    // Error results are single, data-free results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_status != ST_GOOD |->
            out_last && !out_byte_valid && out_payload_byte == 8'd0)
        else $error("malformed error result");

    // Results without data carry zero index and byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_byte_valid |->
            out_byte_index == 5'd0 && out_payload_byte == 8'd0 && out_last)
        else $error("data-free result carries index or data");

    // A byte is only taken when the result register can receive
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> !out_valid || out_ready)
        else $error("byte accepted while result register blocked");

endmodule

bind crc8_serial_frame_parser_core c8sfp_checker u_c8sfp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_status       (out_ch.status),
    .out_byte_index   (out_ch.byte_index),
    .out_payload_byte (out_ch.payload_byte),
    .out_byte_valid   (out_ch.byte_valid),
    .out_last         (out_ch.last)
);

>>> sim/tb.sv
// Self-checking testbench for crc8_serial_frame_parser_core: framed byte streams in,
// checked parser results out. Depends on c8sfp_pkg, c8sfp_byte_if, c8sfp_result_if
// and the core RTL.
module tb;
    import c8sfp_pkg::*;

    localparam int PAYLOAD_DEPTH = 32;

    // Parser phases as the prediction tracks them
    typedef enum logic [2:0] {
        HUNT_H1,
        HUNT_H2,
        GET_ID,
        GET_LEN,
        GET_DATA,
        GET_CRC
    } parse_phase_t;

    // How the trailing check byte of a generated frame is formed
    typedef enum int {
        CRC_OK,      // correct check byte
        CRC_BAD,     // corrupted check byte
        CRC_AS_H1,   // id chosen so the correct check byte equals header1
        CRC_BAD_H1   // wrong check byte, equal to header1 unless the correct one is
    } crc_mode_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] frame_id;
        logic [7:0] frame_length;
        logic [4:0] byte_index;
        logic [7:0] payload_byte;
        logic       byte_valid;
        logic       last;
    } frame_result_t;

    typedef logic [7:0] byte_q_t[$];

    // Predicts parser results from accepted bytes and checks the output stream
    class frame_scoreboard;
        logic [7:0]      hdr1 = 8'hAA;
        logic [7:0]      hdr2 = 8'h55;
        parse_phase_t    phase = HUNT_H1;
        logic [7:0]      id = 8'h00;
        logic [7:0]      len = 8'h00;
        logic [7:0]      crc = 8'h00;
        logic [5:0]      fill = 6'd0;
        logic [7:0]      store [PAYLOAD_DEPTH];
        frame_result_t   expected_q[$];
        int              errors = 0;

        // Bitwise MSB-first CRC-8 update
        static function logic [7:0] crc8_fold(logic [7:0] acc, logic [7:0] b);
            logic [7:0] r;
            logic       fb;
            r = acc;
            for (int i = 7; i >= 0; i--)
            begin
                fb = r[7] ^ b[i];
                r = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
            return r;
        endfunction

        function void set_headers(logic [7:0] h1, logic [7:0] h2);
            hdr1 = h1;
            hdr2 = h2;
        endfunction

        function void push_result(logic [1:0] st, logic [4:0] idx, logic [7:0] d,
                                  logic v, logic l);
            frame_result_t r;
            r = '{status: st, frame_id: id, frame_length: len, byte_index: idx,
                  payload_byte: d, byte_valid: v, last: l};
            expected_q.push_back(r);
        endfunction

        // One accepted input transaction
        function void note_byte(logic [7:0] b);
            case (phase)
                HUNT_H1:
                    if (b == hdr1)
                        phase = HUNT_H2;
                HUNT_H2:
                    // second header wins over a repeated first header
                    if (b == hdr2)
                        phase = GET_ID;
                    else if (b != hdr1)
                        phase = HUNT_H1;
                GET_ID:
                begin
                    id = b;
                    crc = crc8_fold(8'h00, b);
                    phase = GET_LEN;
                end
                GET_LEN:
                begin
                    len = b;
                    crc = crc8_fold(crc, b);
                    fill = 6'd0;
                    if (b > PAYLOAD_DEPTH)
                    begin
                        push_result(ST_LEN_ERR, 5'd0, 8'h00, 1'b0, 1'b1);
                        phase = HUNT_H1;
                    end
                    else
                        phase = (b != 8'h00) ? GET_DATA : GET_CRC;
                end
                GET_DATA:
                begin
                    if (fill < PAYLOAD_DEPTH)
                        store[fill[4:0]] = b;
                    fill = fill + 6'd1;
                    crc = crc8_fold(crc, b);
                    if (fill >= len)
                        phase = GET_CRC;
                end
                GET_CRC:
                begin
                    if (b != crc)
                        push_result(ST_CRC_ERR, 5'd0, 8'h00, 1'b0, 1'b1);
                    else if (len == 8'h00)
                        push_result(ST_GOOD, 5'd0, 8'h00, 1'b0, 1'b1);
                    else
                        for (int i = 0; i < len && i < PAYLOAD_DEPTH; i++)
                            push_result(ST_GOOD, 5'(i), store[i], 1'b1, (i + 1 == len));
                    phase = (b == hdr1) ? HUNT_H2 : HUNT_H1;
                end
                default:
                    phase = HUNT_H1;
            endcase
        endfunction

        function string fmt(frame_result_t r);
            return $sformatf("st=%0d id=%02h len=%02h idx=%0d data=%02h v=%0d last=%0d",
                             r.status, r.frame_id, r.frame_length, r.byte_index,
                             r.payload_byte, r.byte_valid, r.last);
        endfunction

        // One accepted output transaction
        function void check_result(frame_result_t got);
            frame_result_t want;
            bit            bad;
            if (expected_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t unexpected result: %s", $time, fmt(got));
                return;
            end
            want = expected_q.pop_front();
            bad = (got.status !== want.status) || (got.frame_id !== want.frame_id) ||
                  (got.frame_length !== want.frame_length) ||
                  (got.byte_index !== want.byte_index) ||
                  (got.payload_byte !== want.payload_byte) ||
                  (got.byte_valid !== want.byte_valid) || (got.last !== want.last);
            if (bad)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t mismatch: exp %s / act %s", $time, fmt(want), fmt(got));
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_data;

    c8sfp_byte_if   in_ch();
    c8sfp_result_if out_ch();

    frame_scoreboard sb = new;

    bit calm;       // no idling on either side once set
    bit skip_lead;  // parser already sits in the second-header phase
    int counted;    // frame bytes sent in the current traffic phase

    crc8_serial_frame_parser_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Check byte over id, length and payload, as a frame generator needs it
    function automatic logic [7:0] frame_crc(logic [7:0] fid, logic [7:0] flen,
                                             byte_q_t data);
        logic [7:0] acc;
        acc = frame_scoreboard::crc8_fold(8'h00, fid);
        acc = frame_scoreboard::crc8_fold(acc, flen);
        foreach (data[i])
            acc = frame_scoreboard::crc8_fold(acc, data[i]);
        return acc;
    endfunction

    function automatic byte_q_t random_payload(int n);
        byte_q_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom_range(0, 255)));
        return q;
    endfunction

    // Mostly short frames, now and then empty or long ones and the full store
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 8'd0;
        else if (r < 80)
            return 8'($urandom_range(1, 6));
        else if (r < 93)
            return 8'($urandom_range(7, 31));
        else
            return 8'd32;
    endfunction

    // Input side: optional idle burst, then hold valid until the transaction is taken.
    // ready is read right at the edge, so it is the value the core saw.
    task automatic send_byte(input logic [7:0] b);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        sb.note_byte(b);
    endtask

    // Builds one frame from the current sync bytes and sends it
    task automatic drive_frame(input logic [7:0] id, input logic [7:0] len,
                               input byte_q_t data, input crc_mode_t mode,
                               input bit twice_h1);
        byte_q_t    q;
        logic [7:0] fid;
        logic [7:0] chk;
        fid = id;
        if (!skip_lead)
            q.push_back(sb.hdr1);
        if (twice_h1)
            q.push_back(sb.hdr1);
        q.push_back(sb.hdr2);
        skip_lead = 1'b0;
        if (len > PAYLOAD_DEPTH)
        begin
            // length error fires on the length byte; nothing follows
            q.push_back(fid);
            q.push_back(len);
        end
        else
        begin
            // the CRC step is a bijection in the id, so some id always hits header1
            if (mode == CRC_AS_H1)
                for (int k = 0; k < 256; k++)
                    if (frame_crc(8'(k), len, data) == sb.hdr1)
                    begin
                        fid = 8'(k);
                        break;
                    end
            chk = frame_crc(fid, len, data);
            q.push_back(fid);
            q.push_back(len);
            foreach (data[i])
                q.push_back(data[i]);
            case (mode)
                CRC_BAD:    chk = chk ^ 8'($urandom_range(1, 255));
                CRC_BAD_H1: chk = (chk == sb.hdr1) ? ~chk : sb.hdr1;
                default:    ;
            endcase
            q.push_back(chk);
            // a check byte equal to header1 leaves the parser waiting for header2
            skip_lead = (chk == sb.hdr1);
        end
        foreach (q[i])
            send_byte(q[i]);
        counted += q.size();
    endtask

    // Random traffic: mostly well-formed frames, plus errors, cut frames and noise
    task automatic run_traffic(input int budget);
        counted = 0;
        while (counted < budget)
        begin
            int         kind;
            int         cut;
            bit         twice;
            logic [7:0] len;
            kind = $urandom_range(0, 99);
            twice = (sb.hdr1 != sb.hdr2) && ($urandom_range(0, 7) == 0);
            len = pick_len();
            if (kind < 50)
                drive_frame(8'($urandom_range(0, 255)), len, random_payload(len), CRC_OK,
                            twice);
            else if (kind < 60)
                drive_frame(8'($urandom_range(0, 255)), len, random_payload(len), CRC_BAD,
                            twice);
            else if (kind < 65)
                drive_frame(8'($urandom_range(0, 255)), len, random_payload(len),
                            CRC_BAD_H1, twice);
            else if (kind < 73)
                drive_frame(8'h00, len, random_payload(len), CRC_AS_H1, twice);
            else if (kind < 81)
            begin
                case ($urandom_range(0, 3))
                    0:       len = 8'd33;
                    1:       len = 8'hFF;
                    default: len = 8'($urandom_range(33, 255));
                endcase
                drive_frame(8'($urandom_range(0, 255)), len, random_payload(0), CRC_OK,
                            twice);
            end
            else if (kind < 90)
            begin
                // frame cut short inside its payload; what follows is eaten as data
                len = 8'($urandom_range(2, 8));
                cut = $urandom_range(0, len - 1);
                if (!skip_lead)
                    send_byte(sb.hdr1);
                send_byte(sb.hdr2);
                send_byte(8'($urandom_range(0, 255)));
                send_byte(len);
                repeat (cut) send_byte(8'($urandom_range(0, 255)));
                counted += cut + 4;
                skip_lead = 1'b0;
            end
            else if (kind < 95)
            begin
                // false start: header1 followed by a random byte
                send_byte(sb.hdr1);
                send_byte(8'($urandom_range(0, 255)));
                skip_lead = 1'b0;
            end
            else
            begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                skip_lead = 1'b0;
            end
        end
    endtask

    // Let every expected result arrive, then give the core time to settle
    // on a trailing byte that produced no result
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // Both sync bytes, back to back, while the parser is idle
    task automatic set_headers(input logic [7:0] h1, input logic [7:0] h2);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_FIRST_HDR;
        cfg_data  <= h1;
        @(posedge clk);
        cfg_index <= CFG_SECOND_HDR;
        cfg_data  <= h2;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_headers(h1, h2);
    endtask

    // Output side: random stall bursts on ready; every accepted transaction is
    // checked against the oldest prediction.
    initial
    begin
        int            stall;
        frame_result_t got;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
            begin
                got = '{status: out_ch.status, frame_id: out_ch.frame_id,
                        frame_length: out_ch.frame_length, byte_index: out_ch.byte_index,
                        payload_byte: out_ch.payload_byte, byte_valid: out_ch.byte_valid,
                        last: out_ch.last};
                sb.check_result(got);
            end
            if (stall > 0)
            begin
                stall--;
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                stall = $urandom_range(0, 5);
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    // Main sequence
    initial
    begin
        byte_q_t    d;
        logic [7:0] h;
        calm      = 1'b0;
        skip_lead = 1'b0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_FIRST_HDR;
        cfg_data      <= 8'h00;
        in_ch.valid   <= 1'b0;
        in_ch.in_byte <= 8'h00;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed frames with the reset sync bytes
        // repeated header1, then an empty frame with id and length at zero
        drive_frame(8'h00, 8'h00, random_payload(0), CRC_OK, 1'b1);
        // length too large, and equal to header1
        drive_frame(8'hFF, sb.hdr1, random_payload(0), CRC_OK, 1'b0);
        // one-byte frame with a bad check byte
        d = '{8'hFF};
        drive_frame(8'hFF, 8'd1, d, CRC_BAD, 1'b0);
        // good frame whose check byte equals header1
        d = '{8'h00, 8'hFF};
        drive_frame(8'h5A, 8'd2, d, CRC_AS_H1, 1'b0);
        // next frame rides on that check byte: starts at header2, length just too big
        drive_frame(8'h00, 8'd33, random_payload(0), CRC_OK, 1'b0);
        // full payload store
        drive_frame(8'($urandom_range(0, 255)), 8'd32, random_payload(32), CRC_OK, 1'b0);

        run_traffic(20);
        drain();

        // Sync-byte extremes, then equal sync bytes with no idling at all
        set_headers(8'h00, 8'hFF);
        run_traffic(25);
        drain();
        set_headers(8'hFF, 8'h00);
        run_traffic(25);
        drain();
        h = 8'($urandom_range(0, 255));
        set_headers(h, h);
        calm = 1'b1;
        run_traffic(25);
        drain();

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // Watchdog, far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
hdl/c8sfp_pkg.sv
hdl/c8sfp_byte_if.sv
hdl/c8sfp_result_if.sv
hdl/c8sfp_ctrl.sv
hdl/c8sfp_dp.sv
hdl/crc8_serial_frame_parser_core.sv
hdl/c8sfp_checker.sv
sim/tb.sv
